// File: hdl/cgi_pkg.sv
// ----------------------------------------------------------------------------
// cgi_pkg
// shared constants and types of the color gradient interpolator
// ----------------------------------------------------------------------------
package cgi_pkg;

  localparam int MAX_KEYS  = 8;
  localparam int TIME_BITS = 16;

  // key and query times arrive as 16-bit fields
  localparam int TIME_FIELD_W = 16;
  localparam int TIME_W    = (TIME_BITS < TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_REG_W = 4;
  localparam int SCAN_W    = ($clog2(MAX_KEYS + 1) > CNT_REG_W) ?
                             $clog2(MAX_KEYS + 1) : CNT_REG_W;
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 3 * CH_W;
  localparam logic [COLOR_W-1:0] WHITE = {COLOR_W{1'b1}};

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_BLEND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               start;
    logic [TIME_W-1:0]  diff;
    logic [TIME_W-1:0]  span;
    logic [COLOR_W-1:0] color_before;
    logic [COLOR_W-1:0] color_after;
  } blend_req_t;

  typedef struct packed {
    logic               done;
    logic [COLOR_W-1:0] color;
  } blend_rsp_t;

endpackage

// File: hdl/cgi_blend.sv
// ----------------------------------------------------------------------------
// cgi_blend
// bit-serial restoring divider for the blend factor, with the three channel
// mixes accumulated from the quotient bits as they come out msb first
// ----------------------------------------------------------------------------
module cgi_blend
  import cgi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  blend_req_t req,
  output blend_rsp_t rsp
);

  localparam int D_W   = CH_W + 1;
  localparam int ACC_W = D_W + FRAC_BITS;
  localparam int SUM_W = CH_W + FRAC_BITS + 2;
  localparam int STEP_W = $clog2(FRAC_BITS + 1);

  logic                    running;
  logic                    done;
  logic [STEP_W-1:0]       step;
  logic [TIME_W-1:0]       rem;
  logic [TIME_W-1:0]       span;
  logic [COLOR_W-1:0]      color_before;
  logic signed [D_W-1:0]   delta [3];
  logic signed [ACC_W-1:0] acc   [3];

  logic [TIME_W:0]         rem_shift;
  logic [TIME_W:0]         rem_sub;
  logic                    qbit;
  logic [COLOR_W-1:0]      color_out;

  assign rem_shift = {rem, 1'b0};
  assign rem_sub   = rem_shift - {1'b0, span};
  assign qbit      = (rem_shift >= {1'b0, span});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        step    <= STEP_W'(FRAC_BITS);
      end else if (running) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem          <= req.diff;
      span         <= req.span;
      color_before <= req.color_before;
      for (int k = 0; k < 3; k++) begin
        delta[k] <= $signed({1'b0, req.color_after[CH_W*k +: CH_W]}) -
                    $signed({1'b0, req.color_before[CH_W*k +: CH_W]});
        acc[k]   <= '0;
      end
    end else if (running) begin
      rem <= qbit ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
      for (int k = 0; k < 3; k++) begin
        acc[k] <= (acc[k] <<< 1) +
                  (qbit ? {{(ACC_W-D_W){delta[k][D_W-1]}}, delta[k]} : ACC_W'(0));
      end
    end
  end

  // c_before * 2^16 + (c_after - c_before) * f, then drop the fraction
  always_comb begin
    logic [SUM_W-1:0] sum;
    sum       = '0;
    color_out = '0;
    for (int k = 0; k < 3; k++) begin
      sum = {2'b00, color_before[CH_W*k +: CH_W], {FRAC_BITS{1'b0}}} +
            {{(SUM_W-ACC_W){acc[k][ACC_W-1]}}, acc[k]};
      color_out[CH_W*k +: CH_W] = sum[FRAC_BITS +: CH_W];
    end
  end

  assign rsp.done  = done;
  assign rsp.color = color_out;

endmodule

// File: hdl/color_gradient_interpolator_top.sv
// ----------------------------------------------------------------------------
// color_gradient_interpolator_top
// piecewise linear rgb color ramp over a small table of time-stamped keys
// ----------------------------------------------------------------------------
// A word with tuser = 0 writes one color key (slot, time, rgb) and gives no
// result. A word with tuser = 1 is a lookup: the keys in use are scanned one
// per cycle for the first key later than the query time, then the blend factor
// is divided out one quotient bit per cycle while the three channel mixes are
// accumulated from those bits. One word is worked on at a time, and the next
// one is taken as soon as the result is in the output register, even while
// that result still waits on m_axis_tready. key_count is to be written through
// cfg_wr_en / cfg_wr_data only while idle; the block itself does not enforce
// this. key_count resets to 1, and a count of zero makes every lookup return
// white with tuser set.
// The key table resets to time zero and white in every slot.
// ----------------------------------------------------------------------------
module color_gradient_interpolator_top
  import cgi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,   // key_count
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key_index[2:0], key_time[18:3], key_red[26:19], key_green[34:27],
  // key_blue[42:35], query_time[58:43], zero fill[63:59]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tuser,  // kind
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic        m_axis_tuser   // is_default
);

  // input field unpacking
  logic [2:0]  in_key_index;
  logic [15:0] in_key_time;
  logic [7:0]  in_key_red;
  logic [7:0]  in_key_green;
  logic [7:0]  in_key_blue;
  logic [15:0] in_query_time;

  assign in_key_index  = s_axis_tdata[2:0];
  assign in_key_time   = s_axis_tdata[18:3];
  assign in_key_red    = s_axis_tdata[26:19];
  assign in_key_green  = s_axis_tdata[34:27];
  assign in_key_blue   = s_axis_tdata[42:35];
  assign in_query_time = s_axis_tdata[58:43];

  // key table, one flop row per slot
  logic [TIME_W-1:0]  key_times  [MAX_KEYS];
  logic [COLOR_W-1:0] key_colors [MAX_KEYS];

  logic [CNT_REG_W-1:0] key_count;
  state_t               state;
  state_t               state_next;
  logic [SCAN_W-1:0]    idx;
  logic [TIME_W-1:0]    query;
  logic [TIME_W-1:0]    prev_time;
  logic [COLOR_W-1:0]   prev_color;
  logic [COLOR_W-1:0]   res_color;
  logic                 res_default;

  blend_req_t blend_req;
  blend_rsp_t blend_rsp;

  // scan read port and compare
  logic [TIME_W-1:0]  rd_time;
  logic [COLOR_W-1:0] rd_color;
  logic               hit;
  logic               last;
  logic [SCAN_W-1:0]  n_keys;
  logic [SCAN_W-1:0]  count_ext;
  logic               accept;
  logic               is_lookup;
  logic               slot_ok;
  logic               load_out;

  assign count_ext = SCAN_W'(key_count);
  // counts beyond the table size clamp to the table size
  assign n_keys    = (count_ext > SCAN_W'(MAX_KEYS)) ? SCAN_W'(MAX_KEYS) : count_ext;

  assign rd_time  = key_times[idx[IDX_W-1:0]];
  assign rd_color = key_colors[idx[IDX_W-1:0]];
  assign hit      = (rd_time > query);
  assign last     = (SCAN_W'(idx + 1'b1) == n_keys);

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_lookup = (s_axis_tuser == KIND_LOOKUP);
  // writes past the table are dropped
  assign slot_ok   = (32'(in_key_index) < MAX_KEYS);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_lookup) begin
          state_next = (n_keys == '0) ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_next = (idx == '0) ? ST_FINISH : ST_BLEND;
        end else if (last) begin
          state_next = ST_FINISH;
        end
      end
      ST_BLEND: begin
        if (blend_rsp.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    blend_req     = '0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_SEARCH: begin
        // between two keys: start the divider on this pair
        blend_req.start = hit && (idx != '0);
      end
      ST_BLEND: begin
      end
      ST_FINISH: begin
        load_out = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
      end
    endcase
    blend_req.diff         = query - prev_time;
    blend_req.span         = rd_time - prev_time;
    blend_req.color_before = prev_color;
    blend_req.color_after  = rd_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= CNT_REG_W'(1);
    end else if (cfg_wr_en) begin
      key_count <= cfg_wr_data;
    end
  end

  // key table writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_KEYS; i++) begin
        key_times[i]  <= '0;
        key_colors[i] <= WHITE;
      end
    end else if (accept && !is_lookup && slot_ok) begin
      key_times[IDX_W'(in_key_index)]  <= in_key_time[TIME_W-1:0];
      key_colors[IDX_W'(in_key_index)] <= {in_key_red, in_key_green, in_key_blue};
    end
  end

  // scan and result datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx         <= '0;
        query       <= in_query_time[TIME_W-1:0];
        res_color   <= WHITE;
        res_default <= 1'b1;
      end
      ST_SEARCH: begin
        res_default <= 1'b0;
        // before the first key or past the last: that key's color
        res_color   <= rd_color;
        prev_time   <= rd_time;
        prev_color  <= rd_color;
        idx         <= SCAN_W'(idx + 1'b1);
      end
      ST_BLEND: begin
        if (blend_rsp.done) begin
          res_color <= blend_rsp.color;
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {res_color[CH_W-1:0], res_color[CH_W +: CH_W],
                       res_color[2*CH_W +: CH_W]};
      m_axis_tuser <= res_default;
    end
  end

  cgi_blend u_blend (
    .clk (clk),
    .rst (rst),
    .req (blend_req),
    .rsp (blend_rsp)
  );

endmodule
